// ===== rtl/scl_pkg.sv =====
`timescale 1ns / 1ps

package scl_pkg;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int unsigned GROUP = 8;

  typedef struct packed {
    logic       ins;
    logic       del;
    logic [7:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

endpackage

// ===== rtl/scl_cell.sv =====
`timescale 1ns / 1ps

module scl_cell import scl_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CMPW = 7
) (
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [CMPW-1:0] pos,
  input  logic [CMPW-1:0] count,
  input  logic [7:0]      left,
  input  logic [7:0]      right,
  output logic [7:0]      q,
  output logic            hit
);

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (MY_IDX > pos) begin
        data_nxt = left;
      end else if (MY_IDX == pos) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= pos) begin
        data_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q   = data_r;
  assign hit = (data_r == ctrl.value) && (MY_IDX < count);

endmodule

// ===== rtl/scl_scan.sv =====
`timescale 1ns / 1ps

module scl_scan import scl_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = 6
) (
  input  logic             clk,
  input  scan_ctrl_t       ctrl,
  input  logic [DEPTH-1:0] hits,
  output logic             found,
  output logic             last,
  output logic [IW-1:0]    found_idx
);

  localparam int unsigned NG  = (DEPTH + GROUP - 1) / GROUP;
  localparam int unsigned GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned PADW = NG * GROUP;

  logic [PADW-1:0]  hits_pad;
  logic [GW-1:0]    grp_r;
  logic [GW-1:0]    grp_nxt;
  logic [GROUP-1:0] slice;
  logic [2:0]       sub;

  assign hits_pad = PADW'(hits);
  assign slice    = hits_pad[grp_r*GROUP +: GROUP];

  always_comb begin
    sub = 3'd0;
    for (int k = GROUP - 1; k >= 0; k--) begin
      if (slice[k]) begin
        sub = 3'(k);
      end
    end
  end

  assign found     = |slice;
  assign last      = (grp_r == GW'(NG - 1));
  assign found_idx = IW'({grp_r, sub});

  always_comb begin
    grp_nxt = grp_r;
    if (ctrl.clear) begin
      grp_nxt = '0;
    end else if (ctrl.step) begin
      grp_nxt = grp_r + GW'(1);
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule

// ===== rtl/shifting_char_list.sv =====
`timescale 1ns / 1ps
// insert, delete and read execute in the EXEC state after acceptance; their result is registered
// find steps the match scan in EXEC until a hit or the last group, scanning eight cells per cycle
// one transaction at a time: busy is high from acceptance until the result strobe
// synchronous active-low reset empties the list; cell contents are not cleared
// here the receiver cannot stall: out_valid lasts exactly one cycle

module shifting_char_list import scl_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_value,
  input  logic [6:0] in_position,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [5:0] out_index,
  output logic [7:0] out_data,
  output logic [6:0] out_length
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  op_t             op_r;
  logic [7:0]      val_r;
  logic [6:0]      pos_r;
  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  logic [5:0]      index_r, index_nxt;
  logic [7:0]      data_r, data_nxt;
  logic [6:0]      length_r, length_nxt;

  logic [7:0]      cell_q [DEPTH];
  logic [DEPTH-1:0] hits;
  cell_ctrl_t      cctrl;
  scan_ctrl_t      sctrl;
  logic            sc_found, sc_last;
  logic [IW-1:0]   sc_idx;
  logic [CMPW-1:0] pos_w, cnt_w;
  logic            accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign pos_w  = CMPW'(pos_r);
  assign cnt_w  = CMPW'(count_r);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] lft, rgt;
    if (i == 0) begin : g_first
      assign lft = 8'h00;
    end else begin : g_mid_l
      assign lft = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rgt = cell_q[i];
    end else begin : g_mid_r
      assign rgt = cell_q[i+1];
    end
    scl_cell #(.IDX(i), .CMPW(CMPW)) u_cell (
      .clk   (clk),
      .ctrl  (cctrl),
      .pos   (pos_w),
      .count (cnt_w),
      .left  (lft),
      .right (rgt),
      .q     (cell_q[i]),
      .hit   (hits[i])
    );
  end

  scl_scan #(.DEPTH(DEPTH), .IW(IW)) u_scan (
    .clk       (clk),
    .ctrl      (sctrl),
    .hits      (hits),
    .found     (sc_found),
    .last      (sc_last),
    .found_idx (sc_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    index_nxt     = 6'd0;
    data_nxt      = 8'd0;
    length_nxt    = 7'(count_r);
    cctrl.ins     = 1'b0;
    cctrl.del     = 1'b0;
    cctrl.value   = val_r;
    sctrl.clear   = accept;
    sctrl.step    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_FIND: begin
            if (sc_found) begin
              out_valid_nxt = 1'b1;
              index_nxt     = 6'(sc_idx);
              state_nxt     = S_IDLE;
            end else if (sc_last) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_NOTFOUND;
              state_nxt     = S_IDLE;
            end else begin
              sctrl.step = 1'b1;
            end
          end
          OP_INSERT: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (pos_w > cnt_w) begin
              status_nxt = ST_BADPOS;
            end else if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              cctrl.ins  = 1'b1;
              count_nxt  = count_r + CW'(1);
              length_nxt = 7'(count_nxt);
            end
          end
          OP_DELETE: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (pos_w >= cnt_w) begin
              status_nxt = ST_BADPOS;
            end else begin
              cctrl.del  = 1'b1;
              count_nxt  = count_r - CW'(1);
              length_nxt = 7'(count_nxt);
            end
          end
          OP_READ: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (pos_w >= cnt_w) begin
              status_nxt = ST_BADPOS;
            end else begin
              data_nxt = cell_q[pos_w[IW-1:0]];
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_operation);
      val_r <= in_value;
      pos_r <= in_position;
    end
    status_r <= status_nxt;
    index_r  <= index_nxt;
    data_r   <= data_nxt;
    length_r <= length_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_index  = index_r;
  assign out_data   = data_r;
  assign out_length = length_r;

endmodule

// ===== bench/shifting_char_list_tb.sv =====
`timescale 1ns / 1ps

module shifting_char_list_tb;
  import scl_pkg::*;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct {
    status_t    status;
    logic [5:0] index;
    logic [7:0] data;
    logic [6:0] length;
  } list_result_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_operation;
  logic [7:0] in_value;
  logic [6:0] in_position;
  logic       out_valid;
  logic [1:0] out_status;
  logic [5:0] out_index;
  logic [7:0] out_data;
  logic [6:0] out_length;

  logic [7:0]   model_cells [LIST_DEPTH];
  int unsigned  model_len;
  list_result_t pending_results [$];
  list_result_t head_result;
  int unsigned  mismatch_count;
  int unsigned  stall_cycles;
  bit           idle_enable;

  shifting_char_list #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_index   (out_index),
    .out_data    (out_data),
    .out_length  (out_length)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic list_result_t apply_list_op(op_t op, logic [7:0] val, logic [6:0] pos);
    list_result_t r;
    int unsigned  i;
    r.status = ST_OK;
    r.index  = '0;
    r.data   = '0;
    case (op)
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < model_len; i++) begin
          if (model_cells[i[5:0]] == val) begin
            r.status = ST_OK;
            r.index  = i[5:0];
            break;
          end
        end
      end
      OP_INSERT: begin
        if (pos > model_len) begin
          r.status = ST_BADPOS;
        end else if (model_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_len; i > pos; i--) model_cells[i[5:0]] = model_cells[6'(i - 1)];
          model_cells[pos[5:0]] = val;
          model_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= model_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = 32'(pos); i + 1 < model_len; i++)
            model_cells[i[5:0]] = model_cells[6'(i + 1)];
          model_len--;
        end
      end
      default: begin
        if (pos >= model_len) r.status = ST_BADPOS;
        else r.data = model_cells[pos[5:0]];
      end
    endcase
    r.length = model_len[6:0];
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with start still high unless a random idle gap dropped it
  task automatic send_item(op_t op, logic [7:0] val, logic [6:0] pos);
    bit accepted;
    accepted = 1'b0;
    in_operation <= op;
    in_value     <= val;
    in_position  <= pos;
    start        <= 1'b1;
    while (!accepted) begin
      @(posedge clk);
      if (!busy) begin
        accepted = 1'b1;
        pending_results.push_back(apply_list_op(op, val, pos));
      end
      @(negedge clk);
    end
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic send_random(int unsigned ins_w, int unsigned del_w, int unsigned find_w,
                             int unsigned read_w);
    int unsigned pick;
    op_t         op;
    logic [7:0]  val;
    logic [6:0]  pos;
    pick = $urandom_range(0, ins_w + del_w + find_w + read_w - 1);
    if (pick < ins_w) op = OP_INSERT;
    else if (pick < ins_w + del_w) op = OP_DELETE;
    else if (pick < ins_w + del_w + find_w) op = OP_FIND;
    else op = OP_READ;
    // narrow value range now and then so duplicates show up
    if ($urandom_range(0, 3) == 0) val = 8'($urandom_range(0, 7));
    else val = 8'($urandom_range(0, 255));
    if (op == OP_FIND && model_len > 0 && $urandom_range(0, 1) == 1)
      val = model_cells[6'($urandom_range(0, model_len - 1))];
    if ($urandom_range(0, 4) == 0) pos = 7'($urandom_range(0, 127));
    else if (op == OP_INSERT) pos = 7'($urandom_range(0, model_len));
    else if (model_len > 0) pos = 7'($urandom_range(0, model_len - 1));
    else pos = '0;
    send_item(op, val, pos);
  endtask

  task automatic test_empty_list();
    send_item(OP_FIND,   8'h00, 7'd0);
    send_item(OP_READ,   8'h00, 7'd0);
    send_item(OP_DELETE, 8'h00, 7'd0);
    send_item(OP_INSERT, 8'h3c, 7'd1);
    send_item(OP_INSERT, 8'hff, 7'd127);
    send_item(OP_READ,   8'h00, 7'd127);
    send_item(OP_DELETE, 8'h00, 7'd127);
  endtask

  task automatic test_basic_ops();
    send_item(OP_INSERT, 8'h00, 7'd0);
    send_item(OP_INSERT, 8'hff, 7'd1);
    send_item(OP_INSERT, 8'ha5, 7'd0);
    send_item(OP_INSERT, 8'h5a, 7'd2);
    send_item(OP_INSERT, 8'h00, 7'd4);
    send_item(OP_INSERT, 8'h11, 7'd6);
    send_item(OP_FIND,   8'h00, 7'd0);
    send_item(OP_FIND,   8'hff, 7'd0);
    send_item(OP_FIND,   8'h12, 7'd0);
    for (int unsigned p = 0; p < 5; p++) send_item(OP_READ, 8'h00, p[6:0]);
    send_item(OP_READ,   8'h00, 7'd5);
    send_item(OP_DELETE, 8'h00, 7'd5);
    send_item(OP_DELETE, 8'h00, 7'd2);
    send_item(OP_DELETE, 8'h00, 7'd0);
    send_item(OP_DELETE, 8'h00, 7'd2);
    send_item(OP_FIND,   8'h5a, 7'd0);
    send_item(OP_READ,   8'h00, 7'd1);
  endtask

  task automatic test_fill_and_drain(int unsigned rounds);
    repeat (rounds) begin
      while (model_len < LIST_DEPTH) send_random(8, 1, 1, 1);
      send_item(OP_INSERT, 8'h77, 7'd64);
      send_item(OP_INSERT, 8'h77, 7'd0);
      send_item(OP_INSERT, 8'h77, 7'd65);
      send_item(OP_INSERT, 8'h77, 7'd127);
      send_item(OP_READ,   8'h00, 7'd63);
      send_item(OP_READ,   8'h00, 7'd64);
      send_item(OP_DELETE, 8'h00, 7'd64);
      send_item(OP_FIND,   model_cells[LIST_DEPTH - 1], 7'd0);
      repeat (10) send_random(4, 0, 2, 2);
      while (model_len > 0) send_random(1, 8, 1, 1);
    end
  endtask

  task automatic test_random_mix();
    repeat (250) send_random(3, 3, 2, 2);
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (100) send_random(3, 2, 2, 2);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: status %0d index %0d data %h length %0d",
                   out_status, out_index, out_data, out_length);
      end else begin
        head_result = pending_results.pop_front();
        if (out_status !== head_result.status || out_index !== head_result.index ||
            out_data !== head_result.data || out_length !== head_result.length) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: expected status %0d index %0d data %h length %0d",
                     head_result.status, head_result.index, head_result.data,
                     head_result.length);
            $display("          got status %0d index %0d data %h length %0d",
                     out_status, out_index, out_data, out_length);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("** shifting_char_list: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_FIND;
    in_value       = '0;
    in_position    = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    idle_enable    = 1'b1;
    model_len      = 0;
    foreach (model_cells[i]) model_cells[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_fill_and_drain(2);
    test_random_mix();
    test_back_to_back();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("** shifting_char_list: PASSED **");
    end else begin
      $display("** shifting_char_list: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scl_pkg.sv
rtl/scl_cell.sv
rtl/scl_scan.sv
rtl/shifting_char_list.sv
bench/shifting_char_list_tb.sv
